// ----- rtl/core/zspd_pkg.sv -----
// Package with the shared constants, codes and types of the z-score peak detector.
package zspd_pkg;

   localparam int SAMPLE_BITS        = 16;
   localparam int WINDOW_MAX_DEFAULT = 64;

   localparam int LEN_REG_W   = 7;
   localparam int THRESH_W    = 16;
   localparam int INFL_W      = 17;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 2;

   localparam int SUM_OUT_W = 22;
   localparam int SQ_OUT_W  = 37;

   localparam int CHUNK_W   = 24;
   localparam int THR_SHIFT = 16;
   localparam int INFL_FRAC = 16;

   localparam logic [LEN_REG_W-1:0] WINDOW_LENGTH_RESET = LEN_REG_W'(30);
   localparam logic [THRESH_W-1:0]  THRESHOLD_RESET     = THRESH_W'(1280);
   localparam logic [INFL_W-1:0]    INFLUENCE_RESET     = '0;
   localparam logic [INFL_W-1:0]    INFLUENCE_ONE       = INFL_W'(65536);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_LENGTH = 2'd0,
      CSR_THRESHOLD     = 2'd1,
      CSR_INFLUENCE     = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PEAK_NONE = 2'd0,
      PEAK_POS  = 2'd1,
      PEAK_NEG  = 2'd2
   } peak_code_type;

endpackage

// ----- rtl/core/zspd_req_if.sv -----
// Input channel of the z-score peak detector: one sample transfer per handshake.
interface zspd_req_if import zspd_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          restart;

   modport source (output valid, output sample, output restart, input ready);
   modport sink (input valid, input sample, input restart, output ready);
endinterface

// ----- rtl/core/zspd_rsp_if.sv -----
// Result channel of the z-score peak detector: one result transfer per sample.
interface zspd_rsp_if import zspd_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [1:0]                    peak_code;
   logic signed [SAMPLE_BITS-1:0] filtered_sample;
   logic signed [SUM_OUT_W-1:0]   window_sum;
   logic [SQ_OUT_W-1:0]           window_square_sum;
   logic                          window_full;

   modport source (output valid, output peak_code, output filtered_sample, output window_sum,
                   output window_square_sum, output window_full, input ready);
   modport sink (input valid, input peak_code, input filtered_sample, input window_sum,
                 input window_square_sum, input window_full, output ready);
endinterface

// ----- rtl/core/zspd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module zspd_ram import zspd_pkg::*; #(
   parameter int WIDTH = SAMPLE_BITS,
   parameter int DEPTH = WINDOW_MAX_DEFAULT,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/zscore_peak_detector.sv -----
// Top level of the smoothed z-score peak detector with its sequencer and shared multiplier.
//
// The detector takes one signed sample per transfer and returns one result per sample. Once
// the window is full, a sample passes through the states LY, D, AD2, S2, LQLO, LQHI, V1,
// R0 to R4, CMP, F2 and F3 before its result is registered and ST_IDLE takes the next one;
// while the window is still filling it passes only LY, FILL, F2 and F3. The input is not
// ready in between, and a result that is not taken in time holds the next sample in F3.
// The sequence is set by the single 25 x 25 bit multiplier, which the sequencer uses at
// most once per cycle for the mean offset, the squares, the variance and the threshold
// product, which is split into 24-bit partial products summed in one wide accumulator. A
// finished result waits in the output register while the next sample is already being
// taken; a write of window_length clears the window, as restart does.
module zscore_peak_detector import zspd_pkg::*; #(
   parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   zspd_req_if.sink               req_ch,
   zspd_rsp_if.source             rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);
   localparam int LENW  = $clog2(WINDOW_MAX + 1);
   localparam int SLOTW = $clog2(WINDOW_MAX);
   localparam int SUMW  = SAMPLE_BITS + SLOTW;
   localparam int DW    = SUMW + 2;
   localparam int QW    = 2 * SAMPLE_BITS - 2 + LENW;
   localparam int VW    = QW + LENW;
   localparam int T2W   = 2 * THRESH_W;
   localparam int AW    = VW + T2W + 1;
   localparam int LW    = 2 * DW - 2;
   localparam int CW    = (AW > LW + THR_SHIFT) ? AW : LW + THR_SHIFT;
   localparam int MW0   = (DW > VW - CHUNK_W + 1) ? DW : VW - CHUNK_W + 1;
   localparam int MULW  = (MW0 > CHUNK_W + 1) ? MW0 : CHUNK_W + 1;
   localparam int PW    = 2 * MULW;

   typedef enum logic [16:0] {
      ST_IDLE = 17'b00000000000000001,
      ST_LY   = 17'b00000000000000010,
      ST_D    = 17'b00000000000000100,
      ST_AD2  = 17'b00000000000001000,
      ST_S2   = 17'b00000000000010000,
      ST_LQLO = 17'b00000000000100000,
      ST_LQHI = 17'b00000000001000000,
      ST_V1   = 17'b00000000010000000,
      ST_R0   = 17'b00000000100000000,
      ST_R1   = 17'b00000001000000000,
      ST_R2   = 17'b00000010000000000,
      ST_R3   = 17'b00000100000000000,
      ST_R4   = 17'b00001000000000000,
      ST_CMP  = 17'b00010000000000000,
      ST_FILL = 17'b00100000000000000,
      ST_F2   = 17'b01000000000000000,
      ST_F3   = 17'b10000000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [LEN_REG_W-1:0] wl_ff, wl_in;
   logic [THRESH_W-1:0]  th_ff, th_in;
   logic [INFL_W-1:0]    infl_ff, infl_in;

   logic signed [SUMW-1:0]        sum_ff, sum_in;
   logic [QW-1:0]                 sq_ff, sq_in;
   logic [LENW-1:0]               fill_ff, fill_in;
   logic [SLOTW-1:0]              slot_ff, slot_in;
   logic signed [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic signed [SAMPLE_BITS-1:0] y_ff, y_in;
   logic signed [DW-1:0]          d_ff, d_in;
   logic [T2W-1:0]                t2_ff, t2_in;
   logic [LW-1:0]                 lhs_ff, lhs_in;
   logic signed [AW-1:0]          acc_ff, acc_in;
   logic [VW-1:0]                 var_ff, var_in;
   logic signed [PW-1:0]          prod_ff, prod_in;
   logic signed [SAMPLE_BITS-1:0] old_ff, old_in;
   logic signed [SAMPLE_BITS-1:0] f_ff, f_in;
   peak_code_type                 code_ff, code_in;

   logic [1:0]                    rsp_code_ff, rsp_code_in;
   logic signed [SAMPLE_BITS-1:0] rsp_f_ff, rsp_f_in;
   logic signed [SUM_OUT_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic [SQ_OUT_W-1:0]           rsp_sq_ff, rsp_sq_in;
   logic                          rsp_full_ff, rsp_full_in;

   logic signed [MULW-1:0]        mul_a, mul_b;
   logic [LENW-1:0]               len_eff;
   logic [INFL_W-1:0]             w_eff;
   logic [LENW-1:0]               slot_inc;
   logic signed [SAMPLE_BITS:0]   diff;
   logic signed [SUMW-1:0]        sum_next;
   logic [QW-1:0]                 sq_next;
   logic [CW-1:0]                 lhs_ext, rhs_ext;
   logic                          hit;
   logic                          out_free;
   logic                          ram_we;
   logic [SAMPLE_BITS-1:0]        ram_rdata;

   assign len_eff  = (wl_ff < LEN_REG_W'(2)) ? LENW'(2) :
                     (int'(wl_ff) > WINDOW_MAX) ? LENW'(WINDOW_MAX) : LENW'(wl_ff);
   assign w_eff    = (infl_ff > INFLUENCE_ONE) ? INFLUENCE_ONE : infl_ff;
   assign slot_inc = LENW'(slot_ff) + LENW'(1);
   assign diff     = (SAMPLE_BITS + 1)'(y_ff) - (SAMPLE_BITS + 1)'(prev_ff);
   assign sum_next = sum_ff + SUMW'(f_ff);
   assign sq_next  = sq_ff + QW'(prod_ff);
   assign lhs_ext  = CW'({lhs_ff, {THR_SHIFT{1'b0}}});
   assign rhs_ext  = CW'($unsigned(acc_ff));
   assign hit      = lhs_ext > rhs_ext;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign prod_in  = mul_a * mul_b;

   zspd_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_ff),
      .wr_data (f_ff),
      .rd_addr (slot_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      wl_in        = wl_ff;
      th_in        = th_ff;
      infl_in      = infl_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      fill_in      = fill_ff;
      slot_in      = slot_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      y_in         = y_ff;
      d_in         = d_ff;
      t2_in        = t2_ff;
      lhs_in       = lhs_ff;
      acc_in       = acc_ff;
      var_in       = var_ff;
      old_in       = old_ff;
      f_in         = f_ff;
      code_in      = code_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_f_in     = rsp_f_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_sq_in    = rsp_sq_ff;
      rsp_full_in  = rsp_full_ff;
      mul_a        = '0;
      mul_b        = '0;
      ram_we       = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH: begin
               wl_in   = csr_wdata[LEN_REG_W-1:0];
               sum_in  = '0;
               sq_in   = '0;
               fill_in = '0;
               slot_in = '0;
               prev_in = '0;
            end
            CSR_THRESHOLD: begin
               th_in = csr_wdata[THRESH_W-1:0];
            end
            CSR_INFLUENCE: begin
               infl_in = csr_wdata[INFL_W-1:0];
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               y_in     = req_ch.sample;
               state_in = ST_LY;
               if (req_ch.restart) begin
                  sum_in  = '0;
                  sq_in   = '0;
                  fill_in = '0;
                  slot_in = '0;
                  prev_in = '0;
               end else if (LENW'(slot_ff) >= len_eff) begin
                  slot_in = '0;
               end
            end
         end
         ST_LY: begin
            mul_a    = MULW'(len_eff);
            mul_b    = MULW'(y_ff);
            state_in = (fill_ff >= len_eff) ? ST_D : ST_FILL;
         end
         ST_D: begin
            d_in     = DW'(prod_ff) - DW'(sum_ff);
            old_in   = ram_rdata;
            mul_a    = MULW'(th_ff);
            mul_b    = MULW'(th_ff);
            state_in = ST_AD2;
         end
         ST_AD2: begin
            t2_in    = prod_ff[T2W-1:0];
            mul_a    = MULW'(d_ff);
            mul_b    = MULW'(d_ff);
            state_in = ST_S2;
         end
         ST_S2: begin
            lhs_in   = prod_ff[LW-1:0];
            mul_a    = MULW'(sum_ff);
            mul_b    = MULW'(sum_ff);
            state_in = ST_LQLO;
         end
         ST_LQLO: begin
            acc_in   = -AW'(prod_ff);
            mul_a    = MULW'(len_eff);
            mul_b    = MULW'(sq_ff[CHUNK_W-1:0]);
            state_in = ST_LQHI;
         end
         ST_LQHI: begin
            acc_in   = acc_ff + AW'(prod_ff);
            mul_a    = MULW'(len_eff);
            mul_b    = MULW'(sq_ff[QW-1:CHUNK_W]);
            state_in = ST_V1;
         end
         ST_V1: begin
            acc_in   = acc_ff + (AW'(prod_ff) <<< CHUNK_W);
            state_in = ST_R0;
         end
         ST_R0: begin
            var_in   = acc_ff[VW-1:0];
            acc_in   = '0;
            mul_a    = MULW'(t2_ff[CHUNK_W-1:0]);
            mul_b    = MULW'(acc_ff[CHUNK_W-1:0]);
            state_in = ST_R1;
         end
         ST_R1: begin
            acc_in   = acc_ff + AW'(prod_ff);
            mul_a    = MULW'(t2_ff[CHUNK_W-1:0]);
            mul_b    = MULW'(var_ff[VW-1:CHUNK_W]);
            state_in = ST_R2;
         end
         ST_R2: begin
            acc_in   = acc_ff + (AW'(prod_ff) <<< CHUNK_W);
            mul_a    = MULW'(t2_ff[T2W-1:CHUNK_W]);
            mul_b    = MULW'(var_ff[CHUNK_W-1:0]);
            state_in = ST_R3;
         end
         ST_R3: begin
            acc_in   = acc_ff + (AW'(prod_ff) <<< CHUNK_W);
            mul_a    = MULW'(t2_ff[T2W-1:CHUNK_W]);
            mul_b    = MULW'(var_ff[VW-1:CHUNK_W]);
            state_in = ST_R4;
         end
         ST_R4: begin
            acc_in   = acc_ff + (AW'(prod_ff) <<< (2 * CHUNK_W));
            mul_a    = MULW'(w_eff);
            mul_b    = MULW'(diff);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (hit) begin
               f_in    = prev_ff + SAMPLE_BITS'(prod_ff >>> INFL_FRAC);
               code_in = (d_ff > 0) ? PEAK_POS : PEAK_NEG;
            end else begin
               f_in    = y_ff;
               code_in = PEAK_NONE;
            end
            mul_a    = MULW'(old_ff);
            mul_b    = MULW'(old_ff);
            state_in = ST_F2;
         end
         ST_FILL: begin
            f_in     = y_ff;
            code_in  = PEAK_NONE;
            old_in   = '0;
            fill_in  = fill_ff + LENW'(1);
            state_in = ST_F2;
         end
         ST_F2: begin
            sq_in    = sq_ff - QW'(prod_ff);
            sum_in   = sum_ff - SUMW'(old_ff);
            mul_a    = MULW'(f_ff);
            mul_b    = MULW'(f_ff);
            state_in = ST_F3;
         end
         ST_F3: begin
            mul_a = MULW'(f_ff);
            mul_b = MULW'(f_ff);
            if (out_free) begin
               sq_in        = sq_next;
               sum_in       = sum_next;
               ram_we       = 1'b1;
               slot_in      = (slot_inc == len_eff) ? '0 : SLOTW'(slot_inc);
               prev_in      = f_ff;
               rsp_valid_in = 1'b1;
               rsp_code_in  = code_ff;
               rsp_f_in     = f_ff;
               rsp_sum_in   = SUM_OUT_W'(sum_next);
               rsp_sq_in    = SQ_OUT_W'(sq_next);
               rsp_full_in  = fill_ff >= len_eff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wl_ff        <= WINDOW_LENGTH_RESET;
         th_ff        <= THRESHOLD_RESET;
         infl_ff      <= INFLUENCE_RESET;
         sum_ff       <= '0;
         sq_ff        <= '0;
         fill_ff      <= '0;
         slot_ff      <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wl_ff        <= wl_in;
         th_ff        <= th_in;
         infl_ff      <= infl_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         fill_ff      <= fill_in;
         slot_ff      <= slot_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff        <= y_in;
      d_ff        <= d_in;
      t2_ff       <= t2_in;
      lhs_ff      <= lhs_in;
      acc_ff      <= acc_in;
      var_ff      <= var_in;
      prod_ff     <= prod_in;
      old_ff      <= old_in;
      f_ff        <= f_in;
      code_ff     <= code_in;
      rsp_code_ff <= rsp_code_in;
      rsp_f_ff    <= rsp_f_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_sq_ff   <= rsp_sq_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign req_ch.ready              = (state_ff == ST_IDLE);
   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.peak_code          = rsp_code_ff;
   assign rsp_ch.filtered_sample    = rsp_f_ff;
   assign rsp_ch.window_sum         = rsp_sum_ff;
   assign rsp_ch.window_square_sum  = rsp_sq_ff;
   assign rsp_ch.window_full        = rsp_full_ff;
endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench of the z-score peak detector: a directed table, then random phases.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import zspd_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int RANDOM_ITEMS    = 800;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 40;
   localparam int NUM_DIRECTED    = 37;
   localparam int SAMPLE_MAX      = 2 ** (SAMPLE_BITS - 1) - 1;
   localparam int SAMPLE_MIN      = -(2 ** (SAMPLE_BITS - 1));

   typedef struct packed {
      peak_code_type                 code;
      logic signed [SAMPLE_BITS-1:0] filtered;
      logic signed [SUM_OUT_W-1:0]   wsum;
      logic [SQ_OUT_W-1:0]           wsq;
      logic                          full;
   } peak_result_type;

   typedef struct {
      bit                            is_write;
      csr_index_type                 reg_idx;
      logic [CSR_DATA_W-1:0]         reg_val;
      logic signed [SAMPLE_BITS-1:0] smp;
      bit                            rst;
      bit                            typed;
      peak_result_type               result;
   } stim_row_type;

   typedef enum int {RX_ALWAYS, RX_PATTERN, RX_COIN} rx_mode_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   zspd_req_if req_if ();
   zspd_rsp_if rsp_if ();

   zscore_peak_detector uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [LEN_REG_W-1:0] cfg_length;
   logic [THRESH_W-1:0]  cfg_threshold;
   logic [INFL_W-1:0]    cfg_influence;
   longint               win_hist [WINDOW_MAX_DEFAULT];
   longint               win_sum;
   longint               win_sq;
   longint               last_filtered;
   int                   win_fill;
   int                   win_slot;

   peak_result_type pending_peaks [$];
   stim_row_type    directed_rows [NUM_DIRECTED];
   int              fail_count  = 0;
   int              cycle_count = 0;
   int              burst_left  = 0;
   int              holds_asked = 0;
   bit              gaps_on     = 1'b1;

   always #6 clock = ~clock;

   function automatic void clear_window();
      foreach (win_hist[i]) win_hist[i] = 0;
      win_sum       = 0;
      win_sq        = 0;
      win_fill      = 0;
      win_slot      = 0;
      last_filtered = 0;
   endfunction

   function automatic int active_length();
      if (cfg_length < 2) return 2;
      if (cfg_length > WINDOW_MAX_DEFAULT) return WINDOW_MAX_DEFAULT;
      return int'(cfg_length);
   endfunction

   function automatic void apply_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_WINDOW_LENGTH: begin
            cfg_length = val[LEN_REG_W-1:0];
            clear_window();
         end
         CSR_THRESHOLD: cfg_threshold = val[THRESH_W-1:0];
         CSR_INFLUENCE: cfg_influence = val[INFL_W-1:0];
         default: ;
      endcase
   endfunction

   // The z-score test is kept exact in 128 bits: (L*y - S)^2 * 2^16 against T^2 * (L*Q - S^2).
   function automatic peak_result_type predict_peak(input logic signed [SAMPLE_BITS-1:0] smp,
                                                    input logic rst);
      int                  len;
      longint              y, f, d, old, w, acc, t2;
      logic signed [127:0] offset, spread, mean_term, bound;
      peak_result_type     r;
      len = active_length();
      if (rst) clear_window();
      y = smp;
      if (win_slot >= len) win_slot = 0;
      f = y;
      r.code = PEAK_NONE;
      if (win_fill >= len) begin
         d = longint'(len) * y - win_sum;
         t2 = longint'(cfg_threshold) * longint'(cfg_threshold);
         offset = d;
         offset = (offset * offset) <<< 16;
         spread = longint'(len);
         mean_term = win_sum;
         spread = spread * win_sq - mean_term * mean_term;
         bound = t2;
         bound = bound * spread;
         if (offset > bound) begin
            w = (cfg_influence > INFLUENCE_ONE) ? longint'(INFLUENCE_ONE) : longint'(cfg_influence);
            acc = w * y + (longint'(INFLUENCE_ONE) - w) * last_filtered;
            f = acc >>> INFL_FRAC;
            r.code = (d > 0) ? PEAK_POS : PEAK_NEG;
         end
         old = win_hist[win_slot];
         win_sum -= old;
         win_sq -= old * old;
      end else begin
         win_fill++;
      end
      win_hist[win_slot] = f;
      win_sum += f;
      win_sq += f * f;
      win_slot = (win_slot + 1 == len) ? 0 : win_slot + 1;
      last_filtered = f;
      r.filtered = f[SAMPLE_BITS-1:0];
      r.wsum = win_sum[SUM_OUT_W-1:0];
      r.wsq = win_sq[SQ_OUT_W-1:0];
      r.full = (win_fill >= len);
      return r;
   endfunction

   function automatic stim_row_type blank_row();
      stim_row_type row;
      row.is_write = 1'b0;
      row.reg_idx  = CSR_WINDOW_LENGTH;
      row.reg_val  = '0;
      row.smp      = '0;
      row.rst      = 1'b0;
      row.typed    = 1'b0;
      row.result   = '0;
      return row;
   endfunction

   function automatic stim_row_type wr_row(input csr_index_type idx, input int val);
      stim_row_type row;
      row = blank_row();
      row.is_write = 1'b1;
      row.reg_idx = idx;
      row.reg_val = val[CSR_DATA_W-1:0];
      return row;
   endfunction

   function automatic stim_row_type smp_row(input int smp, input bit rst);
      stim_row_type row;
      row = blank_row();
      row.smp = smp[SAMPLE_BITS-1:0];
      row.rst = rst;
      return row;
   endfunction

   function automatic stim_row_type chk_row(input int smp, input bit rst,
                                            input peak_code_type code, input int filt,
                                            input int wsum, input longint wsq, input bit full);
      stim_row_type row;
      row = smp_row(smp, rst);
      row.typed = 1'b1;
      row.result.code = code;
      row.result.filtered = filt[SAMPLE_BITS-1:0];
      row.result.wsum = wsum[SUM_OUT_W-1:0];
      row.result.wsq = wsq[SQ_OUT_W-1:0];
      row.result.full = full;
      return row;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] next_sample(input int base, input int amp);
      int v;
      v = base + int'($urandom_range(0, 2 * amp)) - amp;
      if ($urandom_range(0, 9) == 0)
         v += ($urandom_range(0, 1) ? amp : -amp) * int'($urandom_range(4, 20));
      if ($urandom_range(0, 19) == 0) v = int'($urandom_range(0, 65535)) + SAMPLE_MIN;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      if (v < SAMPLE_MIN) v = SAMPLE_MIN;
      return v[SAMPLE_BITS-1:0];
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want_v,
                                       input logic [63:0] got_v);
      if (got_v !== want_v) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
                  $signed(want_v), $signed(got_v));
      end
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic rst,
                              input bit typed, input peak_result_type typed_res);
      int              gap;
      peak_result_type r;
      gap = 0;
      if (burst_left == 0) begin
         if (gaps_on)
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
         burst_left = $urandom_range(1, 24);
      end
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.sample <= smp;
      req_if.restart <= rst;
      do @(posedge clock); while (!(req_if.valid === 1'b1 && req_if.ready === 1'b1));
      burst_left--;
      r = predict_peak(smp, rst);
      if (typed) r = typed_res;
      pending_peaks = {pending_peaks, r};
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_peaks.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      apply_reg(idx, val);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL zscore_peak_detector");
         $finish;
      end
   end

   always @(posedge clock) begin
      peak_result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_peaks.size() == 0) begin
            fail_count++;
            $display("%0t ns: result transfer with nothing expected", $time);
         end else begin
            want = pending_peaks.pop_front();
            check_field("peak_code", want.code, rsp_if.peak_code);
            check_field("filtered_sample", want.filtered, rsp_if.filtered_sample);
            check_field("window_sum", want.wsum, rsp_if.window_sum);
            check_field("window_square_sum", want.wsq, rsp_if.window_square_sum);
            check_field("window_full", want.full, rsp_if.window_full);
         end
      end
   end

   // The receiver mixes steady, patterned and coin-flip ready, and holds off on request.
   initial begin
      int          hold_left, mode_left, served, step;
      rx_mode_type mode;
      logic [11:0] pattern;
      hold_left = 0;
      mode_left = 0;
      served = 0;
      step = 0;
      mode = RX_ALWAYS;
      pattern = 12'b1011_0111_0010;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (served != holds_asked) begin
            served = holds_asked;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
               RX_ALWAYS: rsp_if.ready <= 1'b1;
               RX_PATTERN: begin
                  rsp_if.ready <= pattern[step % 12];
                  step++;
               end
               default: rsp_if.ready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   initial begin
      int unsigned length_picks [12];
      int          random_sent, count, base, amp;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_WINDOW_LENGTH;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.sample = '0;
      req_if.restart = 1'b0;
      cfg_length = WINDOW_LENGTH_RESET;
      cfg_threshold = THRESHOLD_RESET;
      cfg_influence = INFLUENCE_RESET;
      clear_window();
      length_picks = '{0, 1, 2, 3, 4, 7, 16, 30, 63, 64, 65, 127};
      directed_rows = '{
         chk_row(0, 1'b0, PEAK_NONE, 0, 0, 0, 1'b0),
         chk_row(-32768, 1'b1, PEAK_NONE, -32768, -32768, 1073741824, 1'b0),
         wr_row(CSR_WINDOW_LENGTH, 0),
         chk_row(-32768, 1'b0, PEAK_NONE, -32768, -32768, 1073741824, 1'b0),
         chk_row(32767, 1'b0, PEAK_NONE, 32767, -1, 2147418113, 1'b1),
         smp_row(0, 1'b0),
         smp_row(-32768, 1'b0),
         wr_row(CSR_THRESHOLD, 65535),
         chk_row(5, 1'b1, PEAK_NONE, 5, 5, 25, 1'b0),
         chk_row(5, 1'b0, PEAK_NONE, 5, 10, 50, 1'b1),
         chk_row(6, 1'b0, PEAK_POS, 5, 10, 50, 1'b1),
         chk_row(4, 1'b0, PEAK_NEG, 5, 10, 50, 1'b1),
         chk_row(5, 1'b0, PEAK_NONE, 5, 10, 50, 1'b1),
         wr_row(CSR_INFLUENCE, 131071),
         chk_row(5, 1'b1, PEAK_NONE, 5, 5, 25, 1'b0),
         chk_row(5, 1'b0, PEAK_NONE, 5, 10, 50, 1'b1),
         chk_row(32767, 1'b0, PEAK_POS, 32767, 32772, 1073676314, 1'b1),
         smp_row(-32768, 1'b0),
         wr_row(CSR_THRESHOLD, 0),
         wr_row(CSR_INFLUENCE, 65536),
         smp_row(100, 1'b1),
         smp_row(101, 1'b0),
         smp_row(102, 1'b0),
         smp_row(-3, 1'b0),
         wr_row(CSR_INFLUENCE, 32768),
         smp_row(-7, 1'b0),
         smp_row(9, 1'b0),
         wr_row(CSR_WINDOW_LENGTH, 127),
         smp_row(-1, 1'b0),
         smp_row(32767, 1'b0),
         wr_row(CSR_WINDOW_LENGTH, 1),
         smp_row(1, 1'b0),
         smp_row(-1, 1'b0),
         smp_row(2, 1'b0),
         wr_row(CSR_THRESHOLD, 1280),
         wr_row(CSR_INFLUENCE, 0),
         wr_row(CSR_WINDOW_LENGTH, 64)
      };
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write) begin
            wait_idle();
            write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
         end else begin
            send_sample(directed_rows[i].smp, directed_rows[i].rst, directed_rows[i].typed,
                        directed_rows[i].result);
         end
      end

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         wait_idle();
         if ($urandom_range(0, 2) != 0)
            write_reg(CSR_WINDOW_LENGTH,
                      CSR_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) :
                                  length_picks[$urandom_range(0, 11)]));
         case ($urandom_range(0, 4))
            0: write_reg(CSR_THRESHOLD, 0);
            1: write_reg(CSR_THRESHOLD, 65535);
            4: write_reg(CSR_THRESHOLD, CSR_DATA_W'($urandom_range(0, 65535)));
            default: write_reg(CSR_THRESHOLD, CSR_DATA_W'($urandom_range(128, 1024)));
         endcase
         case ($urandom_range(0, 4))
            0: write_reg(CSR_INFLUENCE, 0);
            1: write_reg(CSR_INFLUENCE, INFLUENCE_ONE);
            2: write_reg(CSR_INFLUENCE, 131071);
            3: write_reg(CSR_INFLUENCE, CSR_DATA_W'($urandom_range(0, 65536)));
            default: write_reg(CSR_INFLUENCE, CSR_DATA_W'($urandom_range(0, 131071)));
         endcase
         gaps_on = ($urandom_range(0, 3) != 0);
         base = int'($urandom_range(0, 60000)) - 30000;
         case ($urandom_range(0, 2))
            0: amp = $urandom_range(0, 16);
            1: amp = $urandom_range(17, 600);
            default: amp = $urandom_range(601, 8000);
         endcase
         count = active_length() + $urandom_range(16, 80);
         // The receiver holds off while a long burst keeps the input offered, so the block stalls.
         if (holds_asked == 0 || (holds_asked == 1 && random_sent > RANDOM_ITEMS / 2)) begin
            holds_asked++;
            burst_left = 60;
         end
         for (int k = 0; k < count; k++) begin
            send_sample(next_sample(base, amp), ($urandom_range(0, 39) == 0), 1'b0, '0);
            random_sent++;
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("PASS zscore_peak_detector");
      else $display("FAIL zscore_peak_detector");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/zspd_pkg.sv
rtl/core/zspd_req_if.sv
rtl/core/zspd_rsp_if.sv
rtl/core/zspd_ram.sv
rtl/core/zscore_peak_detector.sv
bench/tb_top.sv
